>>> src/whe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the weighted histogram engine.
package whe_pkg;

  localparam int WHE_DEF_MAX_BINS = 64;

  localparam int CNT_W     = 32;
  localparam int SUM_W     = 48;
  localparam int OUT_SUM_W = 56;
  localparam int BIN_W     = 7;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_FILL  = 2'd0;
  localparam opcode_t OP_READ  = 2'd1;
  localparam opcode_t OP_INTEG = 2'd2;
  localparam opcode_t OP_CLEAR = 2'd3;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MIN_VALUE   = 2'd0;
  localparam cfg_idx_t CFG_MAX_VALUE   = 2'd1;
  localparam cfg_idx_t CFG_BINS_IN_USE = 2'd2;
  localparam cfg_idx_t CFG_BIN_SCALE   = 2'd3;

  localparam logic signed [31:0] RST_MIN_VALUE   = 32'sd0;
  localparam logic signed [31:0] RST_MAX_VALUE   = 32'sd65536;
  localparam logic [BIN_W-1:0]   RST_BINS_IN_USE = 7'd64;
  localparam logic [31:0]        RST_BIN_SCALE   = 32'd4194304;

  // -1.0 in Q16.16, answered for a bad bin index
  localparam logic signed [OUT_SUM_W-1:0] MINUS_ONE_Q16 = -56'sd65536;

endpackage

>>> src/weighted_histogram_engine.sv
`timescale 1ns / 1ps
// Weighted histogram engine: underflow, N regular and overflow bins in block RAM.
// Requests are taken one at a time: in_stall stays high until the result of the last one has
// been handed to the output register. Fills pass through staged compare, multiply, bin and
// update states; integrals and clears walk the RAM one bin a cycle.
// Reset: synchronous; after reset a clearing pass zeroes the RAMs, with in_stall high.
// Configuration writes are taken at any time.
module weighted_histogram_engine #(
  parameter int MAX_BINS = whe_pkg::WHE_DEF_MAX_BINS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [31:0]                         cfg_wdata,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_opcode,
  input  logic signed [31:0]                  in_sample_value,
  input  logic signed [31:0]                  in_sample_weight,
  input  logic [whe_pkg::BIN_W-1:0]           in_first_bin,
  input  logic [whe_pkg::BIN_W-1:0]           in_last_bin,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [whe_pkg::CNT_W-1:0]           out_entry_count,
  output logic signed [whe_pkg::OUT_SUM_W-1:0] out_weight_sum,
  output logic [whe_pkg::BIN_W-1:0]           out_target_bin,
  output logic                                out_status
);
  import whe_pkg::*;

  // RAM depth: underflow + regular + overflow bins
  localparam int DEPTH = MAX_BINS + 2;
  localparam int AW    = $clog2(DEPTH);
  // bin arithmetic width: covers 7-bit request indexes and n+1
  localparam int CW    = ((AW > BIN_W) ? AW : BIN_W) + 1;
  // integral accumulator, at least one bit past the 56-bit result
  localparam int ACW   = ((SUM_W + AW) > OUT_SUM_W) ? (SUM_W + AW) : (OUT_SUM_W + 1);

  localparam logic [CW-1:0] MAXB     = CW'(MAX_BINS);
  localparam logic [CW-1:0] LAST_IDX = CW'(DEPTH - 1);

  // sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;  // clearing pass over the RAMs
  localparam logic [3:0] S_IDLE = 4'd1;  // waiting for a request
  localparam logic [3:0] S_FCMP = 4'd2;  // fill: range compares, offset
  localparam logic [3:0] S_FMUL = 4'd3;  // fill: offset times scale
  localparam logic [3:0] S_FBIN = 4'd4;  // fill: bin select, RAM read
  localparam logic [3:0] S_FUPD = 4'd5;  // fill: saturating update, write back
  localparam logic [3:0] S_RDW  = 4'd6;  // read: RAM data returns
  localparam logic [3:0] S_INT  = 4'd7;  // integral: stream bins into accumulator
  localparam logic [3:0] S_DONE = 4'd8;  // hand result to the output register

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] min_value_r;
  logic signed [31:0] max_value_r;
  logic [BIN_W-1:0]   bins_in_use_r;
  logic [31:0]        bin_scale_r;

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] addr_r;      // clear counter / integral read pointer
  logic          clr_op_r;    // clearing pass was asked for by a request
  logic          iss_r;       // integral still issuing reads
  logic          rvld_r;      // RAM read data valid for the accumulator
  logic          out_valid_r;

  logic signed [31:0] x_r;
  logic signed [31:0] w_r;
  logic [CW-1:0]      hi_r;
  logic               lt_r, gt_r, eq_r;
  logic [31:0]        diff_r;
  logic [63:0]        prod_r;
  logic [CW-1:0]      tbin_r;
  logic signed [ACW-1:0] acc_r;

  logic [CNT_W-1:0]            res_cnt_r;
  logic signed [OUT_SUM_W-1:0] res_sum_r;
  logic [BIN_W-1:0]            res_bin_r;
  logic                        res_st_r;

  logic [CNT_W-1:0]            out_cnt_r;
  logic signed [OUT_SUM_W-1:0] out_sum_r;
  logic [BIN_W-1:0]            out_bin_r;
  logic                        out_st_r;

  // ---------------------------------------------------------------------------
  // Bin RAMs: one write and one read port, registered read data
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]        cnt_mem [DEPTH];
  logic signed [SUM_W-1:0] sum_mem [DEPTH];
  logic [CNT_W-1:0]        rd_cnt_r;
  logic signed [SUM_W-1:0] rd_sum_r;

  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic [AW-1:0]           mem_ra;
  logic [CNT_W-1:0]        mem_wcnt;
  logic signed [SUM_W-1:0] mem_wsum;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wcnt;
      sum_mem[mem_wa] <= mem_wsum;
    end
    rd_cnt_r <= cnt_mem[mem_ra];
    rd_sum_r <= sum_mem[mem_ra];
  end

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic [CW-1:0] bins_ext, n_act, n_p1, n_m1;
  logic [CW-1:0] b0_ext, b1_ext, lo_c, hi_c;
  logic          accept, out_free, rd_ok, int_ok, int_done;
  logic signed [32:0] diff_c;
  logic [31:0]   q_c;
  logic [CW-1:0] qcl_c, tbin_c;
  logic [CNT_W-1:0] cnt_upd;
  logic signed [SUM_W:0] sum_wide;
  logic signed [SUM_W-1:0] sum_upd;
  logic acc_hi, acc_lo;

  // active bin count: 0 counts as 1, above MAX_BINS is capped
  assign bins_ext = {{(CW-BIN_W){1'b0}}, bins_in_use_r};
  assign n_act    = (bins_in_use_r == '0) ? CW'(1) : ((bins_ext > MAXB) ? MAXB : bins_ext);
  assign n_p1     = n_act + CW'(1);
  assign n_m1     = n_act - CW'(1);

  assign b0_ext = {{(CW-BIN_W){1'b0}}, in_first_bin};
  assign b1_ext = {{(CW-BIN_W){1'b0}}, in_last_bin};
  assign lo_c   = (b0_ext < b1_ext) ? b0_ext : b1_ext;
  assign hi_c   = (b0_ext < b1_ext) ? b1_ext : b0_ext;
  assign rd_ok  = (b0_ext <= n_p1);
  assign int_ok = (b0_ext <= n_p1) && (b1_ext <= n_p1);

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign int_done = !iss_r && !rvld_r;

  // fill binning
  assign diff_c = {x_r[31], x_r} - {min_value_r[31], min_value_r};
  assign q_c    = prod_r[63:32];
  assign qcl_c  = (q_c > {{(32-CW){1'b0}}, n_m1}) ? n_m1 : q_c[CW-1:0];
  always_comb begin
    if (lt_r) begin
      tbin_c = '0;
    end else if (gt_r) begin
      tbin_c = n_p1;
    end else if (eq_r) begin
      tbin_c = n_act;
    end else begin
      tbin_c = qcl_c + CW'(1);
    end
  end

  // saturating bin update
  assign cnt_upd  = (&rd_cnt_r) ? rd_cnt_r : rd_cnt_r + CNT_W'(1);
  assign sum_wide = {rd_sum_r[SUM_W-1], rd_sum_r} + {{(SUM_W-31){w_r[31]}}, w_r};
  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_upd = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_upd = sum_wide[SUM_W-1:0];
    end
  end

  // integral result clamps to the 56-bit signed range
  assign acc_hi = !acc_r[ACW-1] && (|acc_r[ACW-2:OUT_SUM_W-1]);
  assign acc_lo =  acc_r[ACW-1] && !(&acc_r[ACW-2:OUT_SUM_W-1]);

  // RAM port steering
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = addr_r[AW-1:0];
    mem_wcnt = '0;
    mem_wsum = '0;
    mem_ra   = addr_r[AW-1:0];
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_FUPD: begin
        mem_we   = 1'b1;
        mem_wa   = tbin_r[AW-1:0];
        mem_wcnt = cnt_upd;
        mem_wsum = sum_upd;
      end
      S_IDLE: begin
        mem_ra = b0_ext[AW-1:0];
      end
      S_FBIN: begin
        mem_ra = tbin_c[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (addr_r == LAST_IDX) begin
          state_nxt = clr_op_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_FILL:  state_nxt = S_FCMP;
            OP_READ:  state_nxt = rd_ok ? S_RDW : S_DONE;
            OP_INTEG: state_nxt = int_ok ? S_INT : S_DONE;
            OP_CLEAR: state_nxt = S_CLR;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_FCMP:  state_nxt = S_FMUL;
      S_FMUL:  state_nxt = S_FBIN;
      S_FBIN:  state_nxt = S_FUPD;
      S_FUPD:  state_nxt = S_DONE;
      S_RDW:   state_nxt = S_DONE;
      S_INT: begin
        if (int_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // control registers, configuration and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      addr_r        <= '0;
      clr_op_r      <= 1'b0;
      iss_r         <= 1'b0;
      rvld_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      min_value_r   <= RST_MIN_VALUE;
      max_value_r   <= RST_MAX_VALUE;
      bins_in_use_r <= RST_BINS_IN_USE;
      bin_scale_r   <= RST_BIN_SCALE;
    end else begin
      state_r <= state_nxt;
      rvld_r  <= (state_r == S_INT) && iss_r;

      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_VALUE:   min_value_r   <= cfg_wdata;
          CFG_MAX_VALUE:   max_value_r   <= cfg_wdata;
          CFG_BINS_IN_USE: bins_in_use_r <= cfg_wdata[BIN_W-1:0];
          CFG_BIN_SCALE:   bin_scale_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end

      case (state_r)
        S_CLR: begin
          addr_r <= addr_r + CW'(1);
        end
        S_IDLE: begin
          if (accept) begin
            clr_op_r <= (in_opcode == OP_CLEAR);
            if (in_opcode == OP_CLEAR) begin
              addr_r <= '0;
            end else if (in_opcode == OP_INTEG && int_ok) begin
              addr_r <= lo_c;
              iss_r  <= 1'b1;
            end
          end
        end
        S_INT: begin
          if (iss_r) begin
            if (addr_r == hi_r) begin
              iss_r <= 1'b0;
            end else begin
              addr_r <= addr_r + CW'(1);
            end
          end
        end
        default: begin
        end
      endcase

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          x_r       <= in_sample_value;
          w_r       <= in_sample_weight;
          hi_r      <= hi_c;
          acc_r     <= '0;
          res_bin_r <= '0;
          // bad bin index: answer -1 and flag it, nothing is touched
          if (in_opcode == OP_READ && !rd_ok) begin
            res_cnt_r <= '1;
            res_sum_r <= MINUS_ONE_Q16;
            res_st_r  <= 1'b1;
          end else if (in_opcode == OP_INTEG && !int_ok) begin
            res_cnt_r <= '0;
            res_sum_r <= MINUS_ONE_Q16;
            res_st_r  <= 1'b1;
          end else begin
            res_cnt_r <= '0;
            res_sum_r <= '0;
            res_st_r  <= 1'b0;
          end
        end
      end
      S_FCMP: begin
        lt_r   <= (x_r < min_value_r);
        gt_r   <= (x_r > max_value_r);
        eq_r   <= (x_r == max_value_r);
        diff_r <= diff_c[31:0];
      end
      S_FMUL: begin
        prod_r <= diff_r * bin_scale_r;
      end
      S_FBIN: begin
        tbin_r <= tbin_c;
      end
      S_FUPD: begin
        res_bin_r <= tbin_r[BIN_W-1:0];
      end
      S_RDW: begin
        res_cnt_r <= rd_cnt_r;
        res_sum_r <= {{(OUT_SUM_W-SUM_W){rd_sum_r[SUM_W-1]}}, rd_sum_r};
      end
      S_INT: begin
        if (rvld_r) begin
          acc_r <= acc_r + {{(ACW-SUM_W){rd_sum_r[SUM_W-1]}}, rd_sum_r};
        end
        if (int_done) begin
          if (acc_hi) begin
            res_sum_r <= {1'b0, {(OUT_SUM_W-1){1'b1}}};
          end else if (acc_lo) begin
            res_sum_r <= {1'b1, {(OUT_SUM_W-1){1'b0}}};
          end else begin
            res_sum_r <= acc_r[OUT_SUM_W-1:0];
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_cnt_r <= res_cnt_r;
          out_sum_r <= res_sum_r;
          out_bin_r <= res_bin_r;
          out_st_r  <= res_st_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_entry_count = out_cnt_r;
  assign out_weight_sum  = out_sum_r;
  assign out_target_bin  = out_bin_r;
  assign out_status      = out_st_r;

endmodule
